### hdl/aoi_pkg.sv
package aoi_pkg;

  // Table size and coordinate width of the stored positions.
  localparam int MAX_OBJECTS = 64;
  localparam int COORD_BITS  = 16;

  // Widths that follow from the fixed item fields and the constants above.
  localparam int IdW     = 32;
  localparam int InW     = 16;
  localparam int RadiusW = 15;
  localparam int IdxW    = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int SumW    = ((COORD_BITS > InW) ? COORD_BITS : InW) + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [RadiusW-1:0]           radius_t;
  typedef logic [IdxW-1:0]              slot_idx_t;

  // Operation codes.
  localparam logic [1:0] OpEnter = 2'd0;
  localparam logic [1:0] OpLeave = 2'd1;
  localparam logic [1:0] OpMove  = 2'd2;

  // Relation codes.
  localparam logic [1:0] RelSeen   = 2'd0;
  localparam logic [1:0] RelLeaves = 2'd1;
  localparam logic [1:0] RelStays  = 2'd2;
  localparam logic [1:0] RelEnd    = 2'd3;

  // Status codes carried by the end marker.
  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StExists  = 3'd1;
  localparam logic [2:0] StUnknown = 3'd2;
  localparam logic [2:0] StFull    = 3'd3;
  localparam logic [2:0] StNoMove  = 3'd4;

  // One command item.
  typedef struct packed {
    logic [1:0]           opcode;
    logic [IdW-1:0]       object_id;
    logic signed [InW-1:0] pos_x;
    logic signed [InW-1:0] pos_y;
    logic [RadiusW-1:0]   view_radius;
    logic signed [InW-1:0] delta_x;
    logic signed [InW-1:0] delta_y;
  } aoi_in_t;

  // One result item.
  typedef struct packed {
    logic [IdW-1:0] neighbor_id;
    logic [1:0]     relation;
    logic [2:0]     status;
    logic           last;
  } aoi_out_t;

  // One table entry as held in the slot memory.
  typedef struct packed {
    logic [IdW-1:0] id;
    coord_t         x;
    coord_t         y;
    radius_t        radius;
  } aoi_entry_t;

  localparam logic signed [SumW-1:0] CoordHi =
    {{(SumW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [SumW-1:0] CoordLo = ~CoordHi;

  // Clamp a widened value to the signed coordinate range.
  function automatic coord_t sat_coord(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] c;
    c = v;
    if (v > CoordHi) begin
      c = CoordHi;
    end else if (v < CoordLo) begin
      c = CoordLo;
    end
    return c[COORD_BITS-1:0];
  endfunction

endpackage

### hdl/aoi_slot_ram.sv
module aoi_slot_ram #(
  parameter int Depth = 64,
  parameter int Width = 32,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Single read port with registered data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### hdl/aoi_window.sv
module aoi_window (
  input  aoi_pkg::coord_t  center_x_i,
  input  aoi_pkg::coord_t  center_y_i,
  input  aoi_pkg::radius_t radius_i,
  input  aoi_pkg::coord_t  point_x_i,
  input  aoi_pkg::coord_t  point_y_i,
  output logic             hit_o
);
  import aoi_pkg::*;

  localparam int DiffW = COORD_BITS + 1;
  localparam int CmpW  = (DiffW > RadiusW) ? DiffW : RadiusW;

  logic signed [DiffW-1:0] diff_x, diff_y;
  logic [DiffW-1:0]        abs_x, abs_y;

  // Differences cannot overflow one extra bit, and the magnitude fits unsigned.
  assign diff_x = DiffW'(point_x_i) - DiffW'(center_x_i);
  assign diff_y = DiffW'(point_y_i) - DiffW'(center_y_i);
  assign abs_x  = diff_x[DiffW-1] ? DiffW'(-diff_x) : DiffW'(diff_x);
  assign abs_y  = diff_y[DiffW-1] ? DiffW'(-diff_y) : DiffW'(diff_y);

  // Square window: both axes within the radius.
  assign hit_o = (CmpW'(abs_x) <= CmpW'(radius_i)) && (CmpW'(abs_y) <= CmpW'(radius_i));

endmodule

### hdl/area_of_interest_table.sv
// Area-of-interest table: holds up to MAX_OBJECTS objects, each with an id,
// a position and a square view radius.
// Command channel: an item on item_i is taken at a rising edge where start_i
// is high and busy_o is low. busy_o stays high until the end marker is shown.
// Result channel: each result is on result_o for one cycle, marked by
// result_valid_o. The receiver cannot stall, so results are never held back.
// A run lists other objects in ascending slot order, one per cycle at most,
// and closes with an end marker (last set) that carries the status.
// Each operation makes two passes over the slot memory, id lookup and range
// classification, then one commit step in StFinish; a move adds a StPrep step
// for the new position. The end marker is shown in the same cycle as busy_o
// falls, and the next item can already be taken then.
// A rejected command ends after the lookup pass; opcode three or a move with
// zero deltas closes at once with the end marker on the next cycle.
// Reset empties the table by clearing the slot valid flags; the slot memory
// itself is not cleared and needs no clearing pass.
module area_of_interest_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  aoi_pkg::aoi_in_t  item_i,
  output logic              result_valid_o,
  output aoi_pkg::aoi_out_t result_o
);
  import aoi_pkg::*;

  typedef enum logic [4:0] {
    StIdle     = 5'b00001,
    StLookup   = 5'b00010,
    StPrep     = 5'b00100,
    StClassify = 5'b01000,
    StFinish   = 5'b10000
  } state_e;

  localparam logic [IdxW:0] CntEnd = (IdxW+1)'(MAX_OBJECTS);
  localparam int EntryW = $bits(aoi_entry_t);

  state_e state_q, state_d;
  logic [IdxW:0] cnt_q, cnt_d;
  logic pipe_vld_q, pipe_vld_d;
  slot_idx_t pipe_idx_q, pipe_idx_d;
  logic found_q, found_d;
  slot_idx_t slot_q, slot_d;
  logic free_found_q, free_found_d;
  slot_idx_t free_q, free_d;
  logic [2:0] status_q, status_d;
  logic [MAX_OBJECTS-1:0] valid_q, valid_d;
  logic out_vld_q, out_vld_d;

  aoi_in_t in_q, in_d;
  coord_t cx_q, cx_d, cy_q, cy_d, nx_q, nx_d, ny_q, ny_d;
  radius_t r_q, r_d;
  aoi_out_t out_q, out_d;

  logic ram_we, ram_re;
  slot_idx_t ram_waddr, ram_raddr;
  aoi_entry_t ram_wdata, rd_entry;
  logic [EntryW-1:0] ram_rdata;
  logic hit_old, hit_new;
  logic scanning, pass_done, slot_listed;

  // Slot memory holding id, position and radius of every object.
  aoi_slot_ram #(
    .Depth(MAX_OBJECTS),
    .Width(EntryW)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_entry = aoi_entry_t'(ram_rdata);

  // Range tests against the old and the new window of the centre object.
  aoi_window u_win_old (
    .center_x_i(cx_q),
    .center_y_i(cy_q),
    .radius_i  (r_q),
    .point_x_i (rd_entry.x),
    .point_y_i (rd_entry.y),
    .hit_o     (hit_old)
  );

  aoi_window u_win_new (
    .center_x_i(nx_q),
    .center_y_i(ny_q),
    .radius_i  (r_q),
    .point_x_i (rd_entry.x),
    .point_y_i (rd_entry.y),
    .hit_o     (hit_new)
  );

  // Slot scan shared by both passes: one read issued per cycle.
  assign scanning  = (state_q == StLookup) || (state_q == StClassify);
  assign ram_re    = scanning && (cnt_q != CntEnd);
  assign ram_raddr = cnt_q[IdxW-1:0];
  assign pass_done = (cnt_q == CntEnd) && !pipe_vld_q;
  assign slot_listed = valid_q[pipe_idx_q] && !(found_q && (pipe_idx_q == slot_q));

  // Sequencer: lookup, optional position update, classification, commit.
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    pipe_vld_d   = ram_re;
    pipe_idx_d   = ram_raddr;
    found_d      = found_q;
    slot_d       = slot_q;
    free_found_d = free_found_q;
    free_d       = free_q;
    status_d     = status_q;
    valid_d      = valid_q;
    in_d         = in_q;
    cx_d         = cx_q;
    cy_d         = cy_q;
    nx_d         = nx_q;
    ny_d         = ny_q;
    r_d          = r_q;
    out_vld_d    = 1'b0;
    out_d        = out_q;
    ram_we       = 1'b0;
    ram_waddr    = free_q;
    ram_wdata    = '{id: in_q.object_id, x: cx_q, y: cy_q, radius: r_q};
    if (ram_re) begin
      cnt_d = cnt_q + 1'b1;
    end

    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          in_d         = item_i;
          cx_d         = sat_coord(SumW'(item_i.pos_x));
          cy_d         = sat_coord(SumW'(item_i.pos_y));
          r_d          = item_i.view_radius;
          cnt_d        = '0;
          found_d      = 1'b0;
          free_found_d = 1'b0;
          status_d     = StOk;
          case (item_i.opcode)
            OpEnter, OpLeave: begin
              state_d = StLookup;
            end
            OpMove: begin
              if (item_i.delta_x == '0 && item_i.delta_y == '0) begin
                out_vld_d = 1'b1;
                out_d     = '{neighbor_id: '0, relation: RelEnd, status: StNoMove, last: 1'b1};
              end else begin
                state_d = StLookup;
              end
            end
            default: begin
              out_vld_d = 1'b1;
              out_d     = '{neighbor_id: '0, relation: RelEnd, status: StOk, last: 1'b1};
            end
          endcase
        end
      end

      StLookup: begin
        // Id match and lowest free slot, one slot per cycle.
        if (pipe_vld_q) begin
          if (valid_q[pipe_idx_q]) begin
            if (rd_entry.id == in_q.object_id && !found_q) begin
              found_d = 1'b1;
              slot_d  = pipe_idx_q;
              if (in_q.opcode != OpEnter) begin
                cx_d = rd_entry.x;
                cy_d = rd_entry.y;
                r_d  = rd_entry.radius;
              end
            end
          end else if (!free_found_q) begin
            free_found_d = 1'b1;
            free_d       = pipe_idx_q;
          end
        end
        if (pass_done) begin
          cnt_d = '0;
          if (in_q.opcode == OpEnter) begin
            if (found_q) begin
              status_d = StExists;
              state_d  = StFinish;
            end else if (!free_found_q) begin
              status_d = StFull;
              state_d  = StFinish;
            end else begin
              state_d = StClassify;
            end
          end else if (!found_q) begin
            status_d = StUnknown;
            state_d  = StFinish;
          end else if (in_q.opcode == OpMove) begin
            state_d = StPrep;
          end else begin
            state_d = StClassify;
          end
        end
      end

      StPrep: begin
        // New position of the mover, saturated per axis.
        nx_d    = sat_coord(SumW'(cx_q) + SumW'(in_q.delta_x));
        ny_d    = sat_coord(SumW'(cy_q) + SumW'(in_q.delta_y));
        cnt_d   = '0;
        state_d = StClassify;
      end

      StClassify: begin
        // List each other valid object according to the operation.
        if (pipe_vld_q && slot_listed) begin
          out_d = '{neighbor_id: rd_entry.id, relation: RelSeen, status: StOk, last: 1'b0};
          case (in_q.opcode)
            OpEnter: begin
              out_vld_d = hit_old;
            end
            OpLeave: begin
              out_vld_d      = hit_old;
              out_d.relation = RelLeaves;
            end
            default: begin
              out_vld_d = hit_old || hit_new;
              if (hit_old && hit_new) begin
                out_d.relation = RelStays;
              end else if (hit_old) begin
                out_d.relation = RelLeaves;
              end
            end
          endcase
        end
        if (pass_done) begin
          status_d = StOk;
          state_d  = StFinish;
        end
      end

      StFinish: begin
        // Write back a successful operation and close the run.
        out_vld_d = 1'b1;
        out_d     = '{neighbor_id: '0, relation: RelEnd, status: status_q, last: 1'b1};
        if (status_q == StOk) begin
          case (in_q.opcode)
            OpEnter: begin
              ram_we           = 1'b1;
              valid_d[free_q]  = 1'b1;
            end
            OpLeave: begin
              valid_d[slot_q] = 1'b0;
            end
            default: begin
              ram_we    = 1'b1;
              ram_waddr = slot_q;
              ram_wdata = '{id: in_q.object_id, x: nx_q, y: ny_q, radius: r_q};
            end
          endcase
        end
        state_d = StIdle;
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      cnt_q        <= '0;
      pipe_vld_q   <= 1'b0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      status_q     <= StOk;
      valid_q      <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      pipe_vld_q   <= pipe_vld_d;
      found_q      <= found_d;
      free_found_q <= free_found_d;
      status_q     <= status_d;
      valid_q      <= valid_d;
      out_vld_q    <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pipe_idx_q <= pipe_idx_d;
    slot_q     <= slot_d;
    free_q     <= free_d;
    in_q       <= in_d;
    cx_q       <= cx_d;
    cy_q       <= cy_d;
    nx_q       <= nx_d;
    ny_q       <= ny_d;
    r_q        <= r_d;
    out_q      <= out_d;
  end

  assign busy_o         = (state_q != StIdle);
  assign result_valid_o = out_vld_q;
  assign result_o       = out_q;

  // A run is closed only by a marker carrying the end relation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last) |-> (result_o.relation == RelEnd))
    else $error("last set on a result that is not an end marker");

  // Every accepted item either keeps the block busy or closes at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || (result_valid_o && result_o.last)))
    else $error("accepted item produced neither work nor an end marker");

  // Listed objects only appear while an operation is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.last) |-> busy_o)
    else $error("listed object outside an operation");

  // The table gains or loses at most one object per cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (($countones(valid_q) <= $countones($past(valid_q)) + 1) &&
              ($countones($past(valid_q)) <= $countones(valid_q) + 1)))
    else $error("slot occupancy changed by more than one");

  // The slot memory is written only when an operation completes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ((state_q == StFinish) && (status_q == StOk)))
    else $error("slot memory written outside the commit step");

endmodule

### sim/testbench.sv
module testbench;
  import aoi_pkg::*;

  // Opcode three is not an operation; the block answers it with a bare end marker.
  localparam logic [1:0] OpUnused = 2'd3;
  localparam int RandomItems = 410;
  localparam int StallLimit  = 4000;
  localparam int TailCycles  = 2 * MAX_OBJECTS + 16;
  localparam int PoolSize    = 128;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  aoi_in_t   cmd;
  logic      result_valid;
  aoi_out_t  result;

  area_of_interest_table dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_o         (busy),
    .item_i         (cmd),
    .result_valid_o (result_valid),
    .result_o       (result)
  );

  always #1 clk = ~clk;

  // Shadow copy of the object table.
  bit          obj_valid [MAX_OBJECTS];
  logic [31:0] obj_id    [MAX_OBJECTS];
  coord_t      obj_x     [MAX_OBJECTS];
  coord_t      obj_y     [MAX_OBJECTS];
  radius_t     obj_radius[MAX_OBJECTS];

  aoi_out_t    pending_results[$];
  logic [31:0] id_pool[PoolSize];
  int          error_count = 0;
  int          idle_cycles = 0;

  typedef struct {
    aoi_in_t    item;
    bit         has_status;
    logic [2:0] status;
  } directed_row_t;

  directed_row_t directed[$];

  // Clamp a wide value to the signed coordinate range.
  function automatic coord_t clamp_coord(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      v = hi;
    end else if (v < lo) begin
      v = lo;
    end
    return coord_t'(v);
  endfunction

  // Square window test of slot i around (cx, cy).
  function automatic bit in_view(coord_t cx, coord_t cy, radius_t r, int i);
    longint ddx;
    longint ddy;
    ddx = longint'(obj_x[i]) - longint'(cx);
    ddy = longint'(obj_y[i]) - longint'(cy);
    if (ddx < 0) ddx = -ddx;
    if (ddy < 0) ddy = -ddy;
    return (ddx <= longint'(r)) && (ddy <= longint'(r));
  endfunction

  function automatic int slot_of(logic [31:0] id);
    for (int i = 0; i < MAX_OBJECTS; i++) begin
      if (obj_valid[i] && obj_id[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic int first_free_slot();
    for (int i = 0; i < MAX_OBJECTS; i++) begin
      if (!obj_valid[i]) return i;
    end
    return -1;
  endfunction

  task automatic note_result(logic [31:0] id, logic [1:0] rel, logic [2:0] st, bit last,
                             bit post);
    aoi_out_t r;
    r.neighbor_id = id;
    r.relation    = rel;
    r.status      = st;
    r.last        = last;
    if (post) pending_results.push_back(r);
  endtask

  // Apply one command item to the shadow table and queue the run it causes.
  task automatic advance_table(input aoi_in_t c, input bit post);
    int                    hit;
    int                    spare;
    coord_t                px;
    coord_t                py;
    coord_t                nx;
    coord_t                ny;
    radius_t               rad;
    logic signed [InW-1:0] dx;
    logic signed [InW-1:0] dy;
    logic [2:0]            st;
    bit                    was_in;
    bit                    is_in;
    st  = StOk;
    hit = slot_of(c.object_id);
    case (c.opcode)
      OpEnter: begin
        px    = clamp_coord(longint'($signed(c.pos_x)));
        py    = clamp_coord(longint'($signed(c.pos_y)));
        rad   = c.view_radius;
        spare = first_free_slot();
        if (hit >= 0) begin
          st = StExists;
        end else if (spare < 0) begin
          st = StFull;
        end else begin
          for (int i = 0; i < MAX_OBJECTS; i++) begin
            if (obj_valid[i] && in_view(px, py, rad, i)) begin
              note_result(obj_id[i], RelSeen, StOk, 1'b0, post);
            end
          end
          obj_valid[spare]  = 1'b1;
          obj_id[spare]     = c.object_id;
          obj_x[spare]      = px;
          obj_y[spare]      = py;
          obj_radius[spare] = rad;
        end
      end
      OpLeave: begin
        if (hit < 0) begin
          st = StUnknown;
        end else begin
          for (int i = 0; i < MAX_OBJECTS; i++) begin
            if (i != hit && obj_valid[i] &&
                in_view(obj_x[hit], obj_y[hit], obj_radius[hit], i)) begin
              note_result(obj_id[i], RelLeaves, StOk, 1'b0, post);
            end
          end
          obj_valid[hit] = 1'b0;
        end
      end
      OpMove: begin
        dx = c.delta_x;
        dy = c.delta_y;
        // A zero displacement is rejected before the id is looked up.
        if (dx == 0 && dy == 0) begin
          st = StNoMove;
        end else if (hit < 0) begin
          st = StUnknown;
        end else begin
          nx  = clamp_coord(longint'(obj_x[hit]) + longint'(dx));
          ny  = clamp_coord(longint'(obj_y[hit]) + longint'(dy));
          rad = obj_radius[hit];
          for (int i = 0; i < MAX_OBJECTS; i++) begin
            if (i != hit && obj_valid[i]) begin
              was_in = in_view(obj_x[hit], obj_y[hit], rad, i);
              is_in  = in_view(nx, ny, rad, i);
              if (was_in && is_in) begin
                note_result(obj_id[i], RelStays, StOk, 1'b0, post);
              end else if (was_in) begin
                note_result(obj_id[i], RelLeaves, StOk, 1'b0, post);
              end else if (is_in) begin
                note_result(obj_id[i], RelSeen, StOk, 1'b0, post);
              end
            end
          end
          obj_x[hit] = nx;
          obj_y[hit] = ny;
        end
      end
      default: begin
      end
    endcase
    note_result(32'd0, RelEnd, st, 1'b1, post);
  endtask

  function automatic aoi_in_t make_item(logic [1:0] op, logic [31:0] id, int x, int y, int r,
                                        int dx, int dy);
    aoi_in_t c;
    c.opcode      = op;
    c.object_id   = id;
    c.pos_x       = x[InW-1:0];
    c.pos_y       = y[InW-1:0];
    c.view_radius = r[RadiusW-1:0];
    c.delta_x     = dx[InW-1:0];
    c.delta_y     = dy[InW-1:0];
    return c;
  endfunction

  task automatic add_row(aoi_in_t c, bit has_status, logic [2:0] st);
    directed_row_t row;
    row.item       = c;
    row.has_status = has_status;
    row.status     = st;
    directed.push_back(row);
  endtask

  // Id of a random live object, or a pool id when the table is empty.
  function automatic logic [31:0] live_id();
    int live;
    int pick;
    live = 0;
    for (int i = 0; i < MAX_OBJECTS; i++) begin
      if (obj_valid[i]) live++;
    end
    if (live == 0) return id_pool[$urandom_range(0, PoolSize - 1)];
    pick = $urandom_range(0, live - 1);
    for (int i = 0; i < MAX_OBJECTS; i++) begin
      if (obj_valid[i]) begin
        if (pick == 0) return obj_id[i];
        pick--;
      end
    end
    return 32'd0;
  endfunction

  function automatic int rand_coord();
    int m;
    m = $urandom_range(0, 9);
    if (m <= 6) return $urandom_range(0, 800) - 400;
    if (m == 7) return $urandom_range(0, 65535) - 32768;
    if (m == 8) return 32767;
    return -32768;
  endfunction

  function automatic int rand_radius();
    int m;
    m = $urandom_range(0, 9);
    if (m <= 6) return $urandom_range(0, 300);
    if (m == 7) return $urandom_range(0, 32767);
    if (m == 8) return 0;
    return 32767;
  endfunction

  // Random command item; the enter and leave shares set the fill level of the table.
  function automatic aoi_in_t random_item(int enter_pct, int leave_pct);
    aoi_in_t c;
    int      pick;
    int      m;
    c.opcode      = 2'($urandom);
    c.object_id   = $urandom;
    c.pos_x       = InW'($urandom);
    c.pos_y       = InW'($urandom);
    c.view_radius = RadiusW'($urandom);
    c.delta_x     = InW'($urandom);
    c.delta_y     = InW'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      c.opcode = OpUnused;
    end else if (pick < 5 + enter_pct) begin
      c.opcode = OpEnter;
      if ($urandom_range(0, 99) < 85) c.object_id = id_pool[$urandom_range(0, PoolSize - 1)];
      c.pos_x       = InW'(rand_coord());
      c.pos_y       = InW'(rand_coord());
      c.view_radius = RadiusW'(rand_radius());
    end else begin
      c.opcode = (pick < 5 + enter_pct + leave_pct) ? OpLeave : OpMove;
      if ($urandom_range(0, 99) < 75) begin
        c.object_id = live_id();
      end else if ($urandom_range(0, 1) == 1) begin
        c.object_id = id_pool[$urandom_range(0, PoolSize - 1)];
      end
      m = $urandom_range(0, 9);
      if (m <= 5) begin
        c.delta_x = InW'($urandom_range(0, 100) - 50);
        c.delta_y = InW'($urandom_range(0, 100) - 50);
      end else if (m == 6) begin
        c.delta_x = '0;
        c.delta_y = '0;
      end else if (m == 8) begin
        c.delta_x = $urandom_range(0, 1) ? InW'(32767) : InW'(-32768);
        c.delta_y = $urandom_range(0, 1) ? InW'(32767) : InW'(-32768);
      end else if (m == 9) begin
        c.delta_x = '0;
        c.delta_y = InW'($urandom_range(0, 100) - 50);
      end
    end
    return c;
  endfunction

  // Offer one command item, idling at random unless quiet, until the block takes it.
  task automatic issue(input aoi_in_t c, input bit quiet);
    bit drive_now;
    cmd <= c;
    do begin
      drive_now = quiet || ($urandom_range(0, 99) >= 33);
      start <= drive_now;
      @(posedge clk);
    end while (!(drive_now && busy === 1'b0));
  endtask

  // Result checker: every strobed result is matched against the oldest expectation.
  always @(posedge clk) begin
    aoi_out_t want;
    if (rst_n === 1'b1 && result_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10) begin
          $display("unexpected result: id=%h rel=%0d st=%0d last=%0d", result.neighbor_id,
                   result.relation, result.status, result.last);
        end
      end else begin
        want = pending_results.pop_front();
        if (result.neighbor_id !== want.neighbor_id || result.relation !== want.relation ||
            result.status !== want.status || result.last !== want.last) begin
          error_count++;
          if (error_count <= 10) begin
            $display("mismatch: expected id=%h rel=%0d st=%0d last=%0d, got id=%h rel=%0d st=%0d last=%0d",
                     want.neighbor_id, want.relation, want.status, want.last,
                     result.neighbor_id, result.relation, result.status, result.last);
          end
        end
      end
    end
  end

  // Watchdog over cycles in which neither an item nor a result moves.
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((start === 1'b1 && busy === 1'b0) || result_valid === 1'b1) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= StallLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    aoi_in_t c;
    int      enter_pct;
    int      leave_pct;
    rst_n <= 1'b0;
    start <= 1'b0;
    cmd   <= '0;
    for (int i = 0; i < MAX_OBJECTS; i++) obj_valid[i] = 1'b0;
    for (int k = 0; k < PoolSize; k++) id_pool[k] = $urandom;
    id_pool[0] = 32'h0000_0000;
    id_pool[1] = 32'hFFFF_FFFF;
    id_pool[2] = 32'h8000_0000;
    id_pool[3] = 32'h0000_0001;

    // Directed rows: bare end markers are typed in, the rest go through the predictor.
    add_row(make_item(OpEnter, 32'h0, 0, 0, 0, 0, 0), 1'b1, StOk);
    add_row(make_item(OpEnter, 32'h0, 5, 5, 3, 0, 0), 1'b1, StExists);
    add_row(make_item(OpLeave, 32'hFFFF_FFFF, 0, 0, 0, 0, 0), 1'b1, StUnknown);
    add_row(make_item(OpMove, 32'hFFFF_FFFF, 0, 0, 0, 1, 0), 1'b1, StUnknown);
    add_row(make_item(OpMove, 32'h0, 0, 0, 0, 0, 0), 1'b1, StNoMove);
    add_row(make_item(OpMove, 32'hFFFF_FFFF, 0, 0, 0, 0, 0), 1'b1, StNoMove);
    add_row(make_item(OpUnused, 32'h0, 0, 0, 0, 0, 0), 1'b1, StOk);
    add_row(make_item(OpEnter, 32'hFFFF_FFFF, 32767, 32767, 32767, 0, 0), 1'b0, StOk);
    add_row(make_item(OpEnter, 32'h1, -32768, -32768, 32767, 0, 0), 1'b0, StOk);
    add_row(make_item(OpEnter, 32'h2, 0, 0, 0, 0, 0), 1'b0, StOk);
    add_row(make_item(OpEnter, 32'h3, 1, -1, 1, 0, 0), 1'b0, StOk);
    // Saturated moves, including one that ends where it started.
    add_row(make_item(OpMove, 32'hFFFF_FFFF, 0, 0, 0, 32767, 32767), 1'b0, StOk);
    add_row(make_item(OpMove, 32'h1, 0, 0, 0, -32768, -32768), 1'b0, StOk);
    add_row(make_item(OpMove, 32'h2, 0, 0, 0, -32768, 32767), 1'b0, StOk);
    add_row(make_item(OpMove, 32'h2, 0, 0, 0, 32767, -32768), 1'b0, StOk);
    add_row(make_item(OpMove, 32'h0, 0, 0, 0, 1, 0), 1'b0, StOk);
    add_row(make_item(OpMove, 32'h3, 0, 0, 0, -1, 1), 1'b0, StOk);
    add_row(make_item(OpLeave, 32'h1, 0, 0, 0, 0, 0), 1'b0, StOk);
    add_row(make_item(OpLeave, 32'h1, 0, 0, 0, 0, 0), 1'b1, StUnknown);
    add_row(make_item(OpEnter, 32'h1, -32768, 32767, 0, 0, 0), 1'b0, StOk);
    add_row(make_item(OpLeave, 32'hFFFF_FFFF, 0, 0, 0, 0, 0), 1'b0, StOk);
    add_row(make_item(OpEnter, 32'h8000_0000, 100, -100, 32767, 0, 0), 1'b0, StOk);
    add_row(make_item(OpLeave, 32'h0, 0, 0, 0, 0, 0), 1'b0, StOk);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[k]) begin
      issue(directed[k].item, 1'b0);
      if (directed[k].has_status) begin
        note_result(32'd0, RelEnd, directed[k].status, 1'b1, 1'b1);
        advance_table(directed[k].item, 1'b0);
      end else begin
        advance_table(directed[k].item, 1'b1);
      end
    end

    // Random part: mixed traffic, then a fill phase, then mixed traffic again, then a drain.
    for (int n = 0; n < RandomItems; n++) begin
      if (n < 140) begin
        enter_pct = 45;
        leave_pct = 20;
      end else if (n < 260) begin
        enter_pct = 80;
        leave_pct = 5;
      end else if (n < 340) begin
        enter_pct = 40;
        leave_pct = 20;
      end else begin
        enter_pct = 15;
        leave_pct = 55;
      end
      c = random_item(enter_pct, leave_pct);
      issue(c, n >= 200 && n < 280);
      advance_table(c, 1'b1);
    end
    start <= 1'b0;

    // Drain the outstanding runs, then give the block time to show any stray result.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
hdl/aoi_pkg.sv
hdl/aoi_slot_ram.sv
hdl/aoi_window.sv
hdl/area_of_interest_table.sv
sim/testbench.sv
